// ===== hdl/stls_pkg.sv =====
// Shared types, codes and constants of the slope tolerance line segmenter.
package stls_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DEV_W   = 31;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned QUO_W   = COORD_W - 1;
  localparam int unsigned CNT_W   = 5;

  localparam logic [DEV_W-1:0]   DEV_RESET = 31'd7864;
  localparam logic [CNT_W-1:0]   DIV_LAST  = 5'(QUO_W - 1);
  localparam logic [COORD_W-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SLOPE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg_start_x;
    logic signed [COORD_W-1:0] seg_start_y;
    logic signed [COORD_W-1:0] seg_end_x;
    logic signed [COORD_W-1:0] seg_end_y;
    logic                      final_segment;
  } seg_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SECOND = 2'd1,
    PH_INSEG  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECIDE = 3'd1,
    ST_PREP   = 3'd2,
    ST_INIT   = 3'd3,
    ST_DIV    = 3'd4,
    ST_FIX    = 3'd5,
    ST_EVAL   = 3'd6,
    ST_EMIT   = 3'd7
  } ctl_state_t;

  typedef struct packed {
    logic latch;
    logic store_start;
    logic load_diff;
    logic load_abs;
    logic div_init;
    logic div_step;
    logic div_fix;
    logic set_horiz;
    logic set_slope_ref;
    logic upd_prev;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic y_eq_start;
    logic horiz;
    logic hz_ok;
    logic sl_ok;
    logic div_done;
  } dp_status_t;

endpackage

// ===== hdl/stls_ctrl.sv =====
// Controller state machine: point phases, divider sequencing and result handshake.
module stls_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                point_valid,
  output logic                point_ready,
  output logic                seg_valid,
  input  logic                seg_ready,
  input  stls_pkg::dp_status_t sts,
  output stls_pkg::dp_cmd_t    cmd
);
  import stls_pkg::*;

  ctl_state_t state, state_next;
  phase_t     phase, phase_next;
  logic       out_free;

  assign out_free = !seg_valid || seg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_START;
      seg_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd.load_out) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
    end
  end

  // Next state and next phase.
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      ST_IDLE: begin
        if (point_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (phase)
          PH_SECOND: begin
            if (sts.y_eq_start || sts.last) begin
              if (sts.last) begin
                phase_next = PH_START;
                state_next = ST_EMIT;
              end else begin
                phase_next = PH_INSEG;
                state_next = ST_IDLE;
              end
            end else begin
              state_next = ST_PREP;
            end
          end
          PH_INSEG: begin
            if (sts.last) begin
              phase_next = PH_START;
              state_next = ST_EMIT;
            end else begin
              state_next = ST_PREP;
            end
          end
          default: begin
            phase_next = sts.last ? PH_START : PH_SECOND;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_PREP: state_next = ST_INIT;
      ST_INIT: begin
        if (phase == PH_INSEG && sts.horiz) begin
          if (sts.hz_ok) begin
            state_next = ST_IDLE;
          end else begin
            phase_next = PH_START;
            state_next = ST_EMIT;
          end
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_next = ST_FIX;
      end
      ST_FIX: state_next = ST_EVAL;
      ST_EVAL: begin
        if (phase == PH_SECOND) begin
          phase_next = PH_INSEG;
          state_next = ST_IDLE;
        end else if (sts.sl_ok) begin
          state_next = ST_IDLE;
        end else begin
          phase_next = PH_START;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd         = '0;
    point_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        point_ready = 1'b1;
        cmd.latch   = point_valid;
      end
      ST_DECIDE: begin
        cmd.load_diff = 1'b1;
        unique case (phase)
          PH_SECOND: begin
            if (sts.y_eq_start) begin
              cmd.set_horiz = 1'b1;
              cmd.upd_prev  = 1'b1;
            end else if (sts.last) begin
              cmd.upd_prev = 1'b1;
            end
          end
          PH_INSEG: ;
          default: cmd.store_start = !sts.last;
        endcase
      end
      ST_PREP: cmd.load_abs = 1'b1;
      ST_INIT: begin
        if (phase == PH_INSEG && sts.horiz) begin
          cmd.upd_prev = sts.hz_ok;
        end else begin
          cmd.div_init = 1'b1;
        end
      end
      ST_DIV: cmd.div_step = 1'b1;
      ST_FIX: cmd.div_fix = 1'b1;
      ST_EVAL: begin
        if (phase == PH_SECOND) begin
          cmd.set_slope_ref = 1'b1;
          cmd.upd_prev      = 1'b1;
        end else begin
          cmd.upd_prev = sts.sl_ok;
        end
      end
      ST_EMIT: cmd.load_out = out_free;
      default: ;
    endcase
  end

endmodule

// ===== hdl/stls_dp.sv =====
// Datapath: point registers, serial slope divider, tolerance checks and result register.
module stls_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  stls_pkg::point_t     point,
  input  logic                 cfg_write,
  input  logic [30:0]          cfg_data,
  input  stls_pkg::dp_cmd_t    cmd,
  output stls_pkg::dp_status_t sts,
  output stls_pkg::seg_t       seg
);
  import stls_pkg::*;

  point_t                    item;
  logic [DEV_W-1:0]          dev;
  logic [COORD_W-1:0]        start_x, start_y, prev_x, prev_y;
  logic signed [COORD_W-1:0] ref_slope;
  logic                      horiz;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [DIFF_W-1:0]         dmag, nmag;
  logic                      neg, ovf, zero;
  logic [DIFF_W-1:0]         rem;
  logic [QUO_W-1:0]          nlow;
  logic [QUO_W-1:0]          quo;
  logic [CNT_W-1:0]          cnt;
  logic signed [COORD_W-1:0] slope;

  logic [DIFF_W:0]           rem_sh;
  logic                      take;
  logic signed [DIFF_W-1:0]  sdiff;
  logic signed [DIFF_W-1:0]  dev_pos, dev_neg;

  // One restoring step: bring down the next numerator bit and try the subtract.
  assign rem_sh = {rem, nlow[QUO_W-1]};
  assign take   = rem_sh >= {1'b0, dmag};

  assign sdiff   = DIFF_W'(slope) - DIFF_W'(ref_slope);
  assign dev_pos = $signed({2'b00, dev});
  assign dev_neg = -dev_pos;

  assign sts.last       = item.last_point;
  assign sts.y_eq_start = item.point_y == start_y;
  assign sts.horiz      = horiz;
  assign sts.hz_ok      = nmag < {2'b00, dev};
  assign sts.sl_ok      = (sdiff <= dev_pos) && (sdiff >= dev_neg);
  assign sts.div_done   = cnt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev   <= DEV_RESET;
      horiz <= 1'b0;
    end else begin
      if (cfg_write) dev <= cfg_data;
      if (cmd.set_horiz) begin
        horiz <= 1'b1;
      end else if (cmd.set_slope_ref) begin
        horiz <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item <= point;
    if (cmd.store_start) begin
      start_x <= item.point_x;
      start_y <= item.point_y;
    end
    if (cmd.store_start || cmd.upd_prev) begin
      prev_x <= item.point_x;
      prev_y <= item.point_y;
    end
    if (cmd.set_horiz) ref_slope <= '0;
    if (cmd.set_slope_ref) ref_slope <= slope;
    if (cmd.load_diff) begin
      dx <= DIFF_W'(item.point_x) - $signed({prev_x[COORD_W-1], prev_x});
      dy <= DIFF_W'(item.point_y) - $signed({prev_y[COORD_W-1], prev_y});
    end
    if (cmd.load_abs) begin
      dmag <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      nmag <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      neg  <= dx[DIFF_W-1] ^ dy[DIFF_W-1];
    end
    // The quotient of |dy| * 2^16 / |dx| saturates once |dy| >> 15 reaches |dx|;
    // below that only 31 quotient bits remain to be found.
    if (cmd.div_init) begin
      rem  <= {15'd0, nmag[DIFF_W-1:15]};
      ovf  <= {15'd0, nmag[DIFF_W-1:15]} >= dmag;
      zero <= nmag == '0;
      nlow <= {nmag[14:0], {FRAC_W{1'b0}}};
      quo  <= '0;
      cnt  <= DIV_LAST;
    end
    if (cmd.div_step) begin
      rem  <= take ? DIFF_W'(rem_sh - {1'b0, dmag}) : rem_sh[DIFF_W-1:0];
      quo  <= {quo[QUO_W-2:0], take};
      nlow <= {nlow[QUO_W-2:0], 1'b0};
      cnt  <= cnt - CNT_W'(1);
    end
    if (cmd.div_fix) begin
      if (zero) begin
        slope <= '0;
      end else if (ovf) begin
        slope <= neg ? SLOPE_MIN : SLOPE_MAX;
      end else begin
        slope <= neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      end
    end
    if (cmd.load_out) begin
      seg.seg_start_x   <= start_x;
      seg.seg_start_y   <= start_y;
      seg.seg_end_x     <= item.point_x;
      seg.seg_end_y     <= item.point_y;
      seg.final_segment <= item.last_point;
    end
  end

endmodule

// ===== hdl/slope_tolerance_line_segmenter.sv =====
// Slope tolerance line segmenter: top level joining controller and datapath.
//
// Points (signed Q16.16 x, y and a last-point flag) arrive on the point
// channel; each closed segment leaves on the seg channel as start and end
// coordinates plus a flag telling whether the scan's last point closed it.
// Both channels are valid/ready; a transaction completes when both are high.
// The cfg channel writes the 31-bit tolerance (reset value 7864, about 0.12).
// A segment start is latched and decided; a point judged by y difference also
// passes the prep and init states, and a point that needs a slope then runs
// the serial restoring divider: setup, one of 31 quotient bits per cycle, and
// the saturation and tolerance check. A point that closes a segment passes
// the emit state to load the result register. No new point is taken while a
// point is being worked on. A finished result waits in the output register
// without blocking the next point; only a second result waits in its emit
// state until the receiver takes the first. Reset returns the block to waiting
// for a segment start, drops any pending result and restores the tolerance.
module slope_tolerance_line_segmenter (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_ready,
  input  stls_pkg::point_t point,
  output logic             seg_valid,
  input  logic             seg_ready,
  output stls_pkg::seg_t   seg,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [30:0]      cfg_data
);
  import stls_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  stls_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .seg_valid   (seg_valid),
    .seg_ready   (seg_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  stls_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .point     (point),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .seg       (seg)
  );

  // An accepted point is worked on before another one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (point_valid && point_ready) |=> !point_ready)
    else $error("point accepted while the previous one is in progress");

  // A result only appears from the emit step, never while idle.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(seg_valid) |-> !$past(point_ready))
    else $error("result raised outside the emit step");

  // The result register is never overwritten while its transaction is pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!seg_valid || seg_ready))
    else $error("pending result overwritten");

  // Divider phases are exclusive, and none coincides with loading a result.
  a_div_phases: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.div_init, cmd.div_step, cmd.div_fix, cmd.load_out}))
    else $error("conflicting divider commands");

endmodule
